>>> sv/nea_pkg.sv
// ----------------------------------------------------------------------------
// nea_pkg
// Shared types, codes and constants of the neighbor exclusion arbiter.
// ----------------------------------------------------------------------------
package nea_pkg;

  // Default seat count on the ring and fixed field widths
  localparam int SEAT_COUNT_DEF = 5;
  localparam int SEAT_FIELD_W   = 4;
  localparam int CYC_W          = 8;
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 16;

  // Turns per seat after reset
  localparam logic [CYC_W-1:0] TURN_LIMIT_RST = 8'd4;

  // Entries in the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    ACT_REQUEST = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

  typedef enum logic {
    KIND_GRANT  = 1'b0,
    KIND_RECORD = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_THINKING = 2'd0,
    ST_HUNGRY   = 2'd1,
    ST_EATING   = 2'd2,
    ST_FINISHED = 2'd3
  } seat_state_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EMIT = 1'b1
  } bk_state_t;

  // Queued command: only in-range seats get here
  typedef struct packed {
    action_t                 action;
    logic [SEAT_FIELD_W-1:0] seat;
  } item_t;

  // One result record
  typedef struct packed {
    kind_t                   kind;
    logic [SEAT_FIELD_W-1:0] target_seat;
    logic [CYC_W-1:0]        cycles_done;
    logic                    all_finished;
    logic                    last;
  } result_t;

endpackage

>>> sv/nea_front.sv
// ----------------------------------------------------------------------------
// nea_front
// Input side: takes command transfers, drops seats off the ring and queues
// the rest for the back end.
// ----------------------------------------------------------------------------
module nea_front #(
  parameter int SEAT_COUNT = nea_pkg::SEAT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [nea_pkg::IN_TDATA_W-1:0]      in_tdata,   // [3:0] seat
  input  logic [0:0]                          in_tuser,   // [0] action
  output logic                                q_valid,
  output nea_pkg::item_t                      q_item,
  input  logic                                q_pop
);

  localparam int QD     = nea_pkg::QUEUE_DEPTH;
  localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCNT_W = $clog2(QD + 1);
  localparam int SF_W   = nea_pkg::SEAT_FIELD_W;

  nea_pkg::item_t    mem_r [QD];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              in_xfer;
  logic              seat_ok;
  logic              push;
  logic              pop;
  nea_pkg::item_t    in_item;

  // Classify: seats at or above the ring size cause nothing
  assign in_item.action = nea_pkg::action_t'(in_tuser[0]);
  assign in_item.seat   = in_tdata[SF_W-1:0];
  assign seat_ok        = ({1'b0, in_item.seat} < (SF_W + 1)'(SEAT_COUNT));

  assign in_tready = (count_r != QCNT_W'(QD));
  assign in_xfer   = in_tvalid && in_tready;
  assign push      = in_xfer && seat_ok;
  assign pop       = q_pop && q_valid;

  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

>>> sv/nea_back.sv
// ----------------------------------------------------------------------------
// nea_back
// Execution side: holds the seat table, evaluates one queued command per
// pass and plays its result records out through the output register.
// ----------------------------------------------------------------------------
module nea_back #(
  parameter int SEAT_COUNT = nea_pkg::SEAT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [nea_pkg::CYC_W-1:0]           turn_limit,
  input  logic                                q_valid,
  input  nea_pkg::item_t                      q_item,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nea_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [0:0]                          out_tuser,
  output logic                                out_tlast,
  output logic [SEAT_COUNT-1:0]               eat_mask
);

  localparam int SEAT_W = $clog2(SEAT_COUNT);
  localparam int SF_W   = nea_pkg::SEAT_FIELD_W;
  localparam int CW     = nea_pkg::CYC_W;
  localparam int PAD_W  = nea_pkg::OUT_TDATA_W - SF_W - CW - 1;

  // Seat table
  nea_pkg::seat_state_t st_r  [SEAT_COUNT];
  logic [CW-1:0]        cyc_r [SEAT_COUNT];

  // Sequencer and result slots: grant A, grant B, completion record
  nea_pkg::bk_state_t   bk_r, bk_nxt;
  logic [2:0]           pend_r, pend_nxt;
  logic [2:0]           pend_low;
  logic [2:0]           pend_left;
  nea_pkg::result_t     slot_r [3];
  nea_pkg::result_t     out_r;
  logic                 out_valid_r;
  logic                 out_free;
  logic                 emit_go;
  nea_pkg::result_t     emit_data;

  // Evaluation signals
  logic [SEAT_W-1:0]    sidx, l_idx, r_idx;
  logic                 is_rel;
  nea_pkg::seat_state_t self_old;
  logic                 req_ok, rel_ok;
  logic [CW-1:0]        cyc_old, cyc_new, limit;
  logic                 self_done;
  nea_pkg::seat_state_t self_new;
  nea_pkg::seat_state_t s1  [SEAT_COUNT];
  nea_pkg::seat_state_t s2  [SEAT_COUNT];
  nea_pkg::seat_state_t fin [SEAT_COUNT];
  logic [SEAT_COUNT-1:0] can1, can2;
  logic                 req_grant, g_l, g_r;
  logic                 all_fin;
  logic                 any_result;

  // Decode the queued command
  assign sidx     = q_item.seat[SEAT_W-1:0];
  assign is_rel   = (q_item.action == nea_pkg::ACT_RELEASE);
  assign l_idx    = (sidx == '0) ? SEAT_W'(SEAT_COUNT - 1) : sidx - SEAT_W'(1);
  assign r_idx    = (sidx == SEAT_W'(SEAT_COUNT - 1)) ? '0 : sidx + SEAT_W'(1);
  assign self_old = st_r[sidx];
  assign req_ok   = !is_rel && (self_old == nea_pkg::ST_THINKING ||
                                self_old == nea_pkg::ST_HUNGRY);
  assign rel_ok   = is_rel && (self_old == nea_pkg::ST_EATING);

  // Turn count and last-turn test (limit wraps, so 0 acts as 256)
  assign cyc_old   = cyc_r[sidx];
  assign limit     = turn_limit - CW'(1);
  assign self_done = (cyc_old == limit);
  assign cyc_new   = (cyc_old == {CW{1'b1}}) ? cyc_old : cyc_old + CW'(1);
  assign self_new  = is_rel ? (self_done ? nea_pkg::ST_FINISHED : nea_pkg::ST_THINKING)
                            : nea_pkg::ST_HUNGRY;

  // Table update in three ordered passes: own seat, left grant, then right grant or own request grant
  always_comb begin
    for (int i = 0; i < SEAT_COUNT; i++) begin
      s1[i] = ((SEAT_W'(i) == sidx) && (req_ok || rel_ok)) ? self_new : st_r[i];
    end
    for (int i = 0; i < SEAT_COUNT; i++) begin
      can1[i] = (s1[i] == nea_pkg::ST_HUNGRY) &&
                (s1[(i == 0) ? SEAT_COUNT - 1 : i - 1] != nea_pkg::ST_EATING) &&
                (s1[(i == SEAT_COUNT - 1) ? 0 : i + 1] != nea_pkg::ST_EATING);
    end
    req_grant = req_ok && can1[sidx];
    g_l       = rel_ok && can1[l_idx];
    for (int i = 0; i < SEAT_COUNT; i++) begin
      s2[i] = (g_l && (SEAT_W'(i) == l_idx)) ? nea_pkg::ST_EATING : s1[i];
    end
    for (int i = 0; i < SEAT_COUNT; i++) begin
      can2[i] = (s2[i] == nea_pkg::ST_HUNGRY) &&
                (s2[(i == 0) ? SEAT_COUNT - 1 : i - 1] != nea_pkg::ST_EATING) &&
                (s2[(i == SEAT_COUNT - 1) ? 0 : i + 1] != nea_pkg::ST_EATING);
    end
    g_r     = rel_ok && can2[r_idx];
    all_fin = 1'b1;
    for (int i = 0; i < SEAT_COUNT; i++) begin
      fin[i] = ((g_r && (SEAT_W'(i) == r_idx)) || (req_grant && (SEAT_W'(i) == sidx)))
               ? nea_pkg::ST_EATING : s2[i];
      all_fin = all_fin && (fin[i] == nea_pkg::ST_FINISHED);
    end
  end

  assign any_result = req_grant || rel_ok;

  // Pending slot selection, lowest slot first
  assign pend_low  = pend_r & (~pend_r + 3'd1);
  assign pend_left = pend_r & ~pend_low;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    priority if (pend_r[0]) begin
      emit_data = slot_r[0];
    end else if (pend_r[1]) begin
      emit_data = slot_r[1];
    end else begin
      emit_data = slot_r[2];
    end
  end

  // Sequencer: next state
  always_comb begin
    bk_nxt = bk_r;
    unique case (bk_r)
      nea_pkg::BK_IDLE: begin
        if (q_valid && any_result) begin
          bk_nxt = nea_pkg::BK_EMIT;
        end
      end
      nea_pkg::BK_EMIT: begin
        if (out_free && (pend_left == '0)) begin
          bk_nxt = nea_pkg::BK_IDLE;
        end
      end
      default: bk_nxt = nea_pkg::BK_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    q_pop    = 1'b0;
    emit_go  = 1'b0;
    pend_nxt = pend_r;
    unique case (bk_r)
      nea_pkg::BK_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          pend_nxt = {rel_ok, g_r, g_l || req_grant};
        end
      end
      nea_pkg::BK_EMIT: begin
        emit_go = out_free;
        if (out_free) begin
          pend_nxt = pend_left;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Control state and seat table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_r        <= nea_pkg::BK_IDLE;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SEAT_COUNT; i++) begin
        st_r[i]  <= nea_pkg::ST_THINKING;
        cyc_r[i] <= '0;
      end
    end else begin
      bk_r   <= bk_nxt;
      pend_r <= pend_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        for (int i = 0; i < SEAT_COUNT; i++) begin
          st_r[i] <= fin[i];
        end
        if (rel_ok) begin
          cyc_r[sidx] <= cyc_new;
        end
      end
    end
  end

  // Result slots and output register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      slot_r[0].kind         <= nea_pkg::KIND_GRANT;
      slot_r[0].target_seat  <= SF_W'(is_rel ? l_idx : sidx);
      slot_r[0].cycles_done  <= '0;
      slot_r[0].all_finished <= 1'b0;
      slot_r[0].last         <= !is_rel;
      slot_r[1].kind         <= nea_pkg::KIND_GRANT;
      slot_r[1].target_seat  <= SF_W'(r_idx);
      slot_r[1].cycles_done  <= '0;
      slot_r[1].all_finished <= 1'b0;
      slot_r[1].last         <= 1'b0;
      slot_r[2].kind         <= nea_pkg::KIND_RECORD;
      slot_r[2].target_seat  <= SF_W'(sidx);
      slot_r[2].cycles_done  <= cyc_new;
      slot_r[2].all_finished <= all_fin;
      slot_r[2].last         <= 1'b1;
    end
    if (emit_go) begin
      out_r <= emit_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_r.all_finished, out_r.cycles_done,
                       out_r.target_seat};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_r.last;

  // Seats currently holding the resource
  always_comb begin
    for (int i = 0; i < SEAT_COUNT; i++) begin
      eat_mask[i] = (st_r[i] == nea_pkg::ST_EATING);
    end
  end

endmodule

>>> sv/neighbor_exclusion_arbiter.sv
// ----------------------------------------------------------------------------
// neighbor_exclusion_arbiter
// Ring arbiter where adjacent seats never hold the resource together.
// ----------------------------------------------------------------------------
// Each command transfer (request or release for one seat) lands in a
// two-entry queue and is evaluated by the back end in a single pass; the
// back end then sends its records, one per cycle while out_tready allows,
// through a registered output. A granted request yields its grant record,
// a release up to two neighbor grants plus its completion record; commands
// that cause nothing yield no record. Evaluation and output share a
// single sequencer, so no new command is taken while records of the last
// one are still going out. The seat table resets at once, with no clearing
// pass. The turn limit is written through cfg_we/cfg_wdata and must only
// change while no command is in flight.
// ----------------------------------------------------------------------------
module neighbor_exclusion_arbiter #(
  parameter int SEAT_COUNT = nea_pkg::SEAT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [nea_pkg::IN_TDATA_W-1:0]      in_tdata,   // [3:0] seat, [7:4] zero
  input  logic [0:0]                          in_tuser,   // [0] action
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [nea_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [3:0] target_seat,
                                                          // [11:4] cycles_done,
                                                          // [12] all_finished
  output logic [0:0]                          out_tuser,  // [0] kind
  output logic                                out_tlast,
  // configuration
  input  logic                                cfg_we,
  input  logic [nea_pkg::CYC_W-1:0]           cfg_wdata   // turn limit
);

  logic [nea_pkg::CYC_W-1:0] turn_limit_r;
  logic                      q_valid;
  nea_pkg::item_t            q_item;
  logic                      q_pop;
  logic [SEAT_COUNT-1:0]     eat_mask;
  logic [SEAT_COUNT-1:0]     clash;

  // Turn limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_limit_r <= nea_pkg::TURN_LIMIT_RST;
    end else if (cfg_we) begin
      turn_limit_r <= cfg_wdata;
    end
  end

  nea_front #(
    .SEAT_COUNT (SEAT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  nea_back #(
    .SEAT_COUNT (SEAT_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .turn_limit (turn_limit_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .eat_mask   (eat_mask)
  );

  // Adjacent seats both eating
  always_comb begin
    for (int i = 0; i < SEAT_COUNT; i++) begin
      clash[i] = eat_mask[i] && eat_mask[(i == SEAT_COUNT - 1) ? 0 : i + 1];
    end
  end

  // Exclusion invariant on the ring
  a_no_neighbor_clash: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> (clash == '0))
    else $error("two neighboring seats eating");

  // A completion record always closes its command's records
  a_record_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[0] == nea_pkg::KIND_RECORD)) |-> out_tlast)
    else $error("completion record without tlast");

  // Grant records carry no count and no all-finished flag
  a_grant_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[0] == nea_pkg::KIND_GRANT)) |-> (out_tdata[12:4] == '0))
    else $error("grant record with nonzero count or flag");

  // Records of one command leave back to back
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("gap inside a command's records");

endmodule
